[sv/mclr_pkg.sv]
// Package for the multi-channel load cell reader: field structs, register
// indexes, microcode word layout and the microcode ROM.
// Depends on nothing; every other file of the block imports it.
package mclr_pkg;

   // Fixed field widths and read timing.
   localparam int CHANNELS_DEFAULT = 4;
   localparam int SAMPLE_BITS      = 24;
   localparam int LINE_W           = 4;
   localparam int MS_W             = 16;
   localparam int CH_W             = 2;
   localparam int HALF_TOTAL       = 2 * (SAMPLE_BITS + 1);
   localparam int SHIFT_HALVES     = 2 * SAMPLE_BITS;
   localparam int HP_W             = $clog2(HALF_TOTAL + 1);

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_STALE_LIMIT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_LIMIT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_ENABLE = 2'd2;

   localparam logic [MS_W-1:0]   STALE_RESET  = 16'd1000;
   localparam logic [MS_W-1:0]   WAIT_RESET   = 16'd10;
   localparam logic [LINE_W-1:0] ENABLE_RESET = 4'hF;

   // One input beat.
   typedef struct packed {
      logic [LINE_W-1:0] dout_levels;
      logic              ms_strobe;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic                          sck;
      logic                          sample_valid;
      logic [CH_W-1:0]               channel;
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic                          last;
   } rsp_type;

   // Configuration register file contents.
   typedef struct packed {
      logic [MS_W-1:0]   stale_limit;
      logic [MS_W-1:0]   wait_limit;
      logic [LINE_W-1:0] enable;
   } cfg_type;

   // Datapath operations and jump conditions of the microcode.
   typedef enum logic [1:0] {OP_NONE, OP_POLL, OP_CLOCK, OP_EMIT} op_type;
   typedef enum logic [1:0] {COND_NEVER, COND_START, COND_FINISH, COND_MORE} cond_type;

   // Microprogram addresses.
   localparam int STEP_W = 2;
   typedef logic [STEP_W-1:0] step_type;
   localparam step_type STEP_POLL  = 2'd0;
   localparam step_type STEP_CLOCK = 2'd1;
   localparam step_type STEP_EMIT  = 2'd2;

   // One control word.
   typedef struct packed {
      logic     wait_in;
      logic     wait_out;
      op_type   op;
      cond_type cond;
      step_type jump_step;
      step_type next_step;
   } uword_type;

   // Sequencer to datapath.
   typedef struct packed {
      op_type op;
      logic   fire;
   } ctl_type;

   // Datapath to sequencer.
   typedef struct packed {
      logic out_free;
      logic start;
      logic finish;
      logic more;
   } status_type;

   // Microcode ROM. Polling stays put until a read starts, the clock step
   // runs the half periods, the emit step loops once per sampled channel.
   function automatic uword_type ucode_rom(step_type step);
      uword_type w;
      unique case (step)
         STEP_POLL: begin
            w = '{wait_in: 1'b1, wait_out: 1'b1, op: OP_POLL, cond: COND_START,
                  jump_step: STEP_CLOCK, next_step: STEP_POLL};
         end
         STEP_CLOCK: begin
            w = '{wait_in: 1'b1, wait_out: 1'b1, op: OP_CLOCK, cond: COND_FINISH,
                  jump_step: STEP_EMIT, next_step: STEP_CLOCK};
         end
         STEP_EMIT: begin
            w = '{wait_in: 1'b0, wait_out: 1'b1, op: OP_EMIT, cond: COND_MORE,
                  jump_step: STEP_EMIT, next_step: STEP_POLL};
         end
         default: begin
            w = '{wait_in: 1'b0, wait_out: 1'b0, op: OP_NONE, cond: COND_NEVER,
                  jump_step: STEP_POLL, next_step: STEP_POLL};
         end
      endcase
      return w;
   endfunction

   // Millisecond counter increment that sticks at all ones.
   function automatic logic [MS_W-1:0] sat_inc(logic [MS_W-1:0] v);
      return (v == '1) ? v : v + MS_W'(1);
   endfunction

endpackage

[sv/mclr_sequencer.sv]
// Microcode sequencer: step counter, ROM lookup, jump selection and the
// input-side stall. Depends on mclr_pkg.
module mclr_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  mclr_pkg::status_type   status,
   output mclr_pkg::ctl_type      ctl,
   output logic                   req_stall
);
   import mclr_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   uword_type uword;
   logic      cond_true;
   logic      fire;

   // Control word of the current step.
   assign uword = ucode_rom(step_ff);

   // Jump condition select.
   always_comb begin
      unique case (uword.cond)
         COND_START:  cond_true = status.start;
         COND_FINISH: cond_true = status.finish;
         COND_MORE:   cond_true = status.more;
         default:     cond_true = 1'b0;
      endcase
   end

   // Each step runs once its output slot and any needed input are there.
   assign req_stall = !(uword.wait_in && (!uword.wait_out || status.out_free));
   assign fire      = (!uword.wait_in || (req_valid && !req_stall))
                   && (!uword.wait_out || status.out_free);

   assign ctl = '{op: uword.op, fire: fire};

   // Next step address.
   always_comb begin
      step_in = step_ff;
      if (fire) begin
         step_in = cond_true ? uword.jump_step : uword.next_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_POLL;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

[sv/mclr_datapath.sv]
// Datapath of the load cell reader: channel ages, wait timer, half-period
// counter, per-channel shift registers, sample mask and the result register.
// Depends on mclr_pkg; driven by mclr_sequencer.
module mclr_datapath #(
   parameter int CHANNELS = mclr_pkg::CHANNELS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mclr_pkg::ctl_type      ctl,
   input  mclr_pkg::cfg_type      cfg,
   input  mclr_pkg::req_type      req_payload,
   input  logic                   rsp_stall,
   output mclr_pkg::status_type   status,
   output logic                   rsp_valid,
   output mclr_pkg::rsp_type      rsp_payload
);
   import mclr_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam rsp_type EMPTY_RSP = '{sck: 1'b0, sample_valid: 1'b0, channel: '0,
                                     sample_value: '0, last: 1'b1};

   logic [MS_W-1:0]        age_ff   [CHANNELS];
   logic [MS_W-1:0]        age_in   [CHANNELS];
   logic [MS_W-1:0]        age_inc  [CHANNELS];
   logic [SAMPLE_BITS-1:0] shift_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] shift_in [CHANNELS];
   logic                   waiting_ff, waiting_in;
   logic [MS_W-1:0]        elapsed_ff, elapsed_in;
   logic [HP_W-1:0]        hp_ff, hp_in;
   logic [CHANNELS-1:0]    mask_ff, mask_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff;

   logic [LINE_W-1:0]      levels;
   logic                   strobe;
   logic [LINE_W-1:0]      ready;
   logic                   all_ready;
   logic [MS_W-1:0]        elapsed_new;
   logic [HP_W-1:0]        hp_new;
   logic                   shift_now;
   logic [IDX_W-1:0]       sel_idx;
   logic [CHANNELS-1:0]    sel_hot;
   logic [CHANNELS-1:0]    mask_rest;
   logic                   load_rsp;
   rsp_type                rsp_data;

   assign levels = req_payload.dout_levels;
   assign strobe = req_payload.ms_strobe;

   // Ages advance on every millisecond beat; the poll then checks liveness.
   always_comb begin
      all_ready = 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
         age_inc[i] = strobe ? sat_inc(age_ff[i]) : age_ff[i];
         if (!ready[i % LINE_W] && cfg.enable[i % LINE_W] && age_inc[i] < cfg.stale_limit) begin
            all_ready = 1'b0;
         end
      end
   end

   assign ready = ~levels & cfg.enable;

   // The first ready beat counts as time zero of the wait.
   assign elapsed_new = waiting_ff ? (strobe ? sat_inc(elapsed_ff) : elapsed_ff) : '0;

   assign hp_new    = hp_ff + HP_W'(1);
   assign shift_now = !hp_new[0] && (hp_new <= HP_W'(SHIFT_HALVES));

   // Lowest pending channel of the sample mask.
   always_comb begin
      sel_idx = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel_idx = IDX_W'(i);
         end
      end
   end

   assign sel_hot   = mask_ff & (~mask_ff + CHANNELS'(1));
   assign mask_rest = mask_ff & ~sel_hot;

   // Status toward the sequencer.
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.start    = (ready != '0) && (all_ready || elapsed_new >= cfg.wait_limit);
   assign status.finish   = hp_new >= HP_W'(HALF_TOTAL);
   assign status.more     = mask_rest != '0;

   // Next state of the datapath for the operation the current step names.
   always_comb begin
      age_in     = age_ff;
      shift_in   = shift_ff;
      waiting_in = waiting_ff;
      elapsed_in = elapsed_ff;
      hp_in      = hp_ff;
      mask_in    = mask_ff;
      load_rsp   = 1'b0;
      rsp_data   = EMPTY_RSP;
      if (ctl.fire) begin
         case (ctl.op)
            OP_POLL: begin
               load_rsp = 1'b1;
               for (int i = 0; i < CHANNELS; i++) begin
                  age_in[i] = ready[i % LINE_W] ? '0 : age_inc[i];
               end
               if (ready == '0) begin
                  waiting_in = 1'b0;
                  elapsed_in = '0;
               end else if (status.start) begin
                  // Read starts: snapshot the ready channels, raise the clock.
                  waiting_in   = 1'b0;
                  elapsed_in   = '0;
                  hp_in        = HP_W'(1);
                  rsp_data.sck = 1'b1;
                  for (int i = 0; i < CHANNELS; i++) begin
                     mask_in[i]  = ready[i % LINE_W];
                     shift_in[i] = '0;
                  end
               end else begin
                  waiting_in = 1'b1;
                  elapsed_in = elapsed_new;
               end
            end
            OP_CLOCK: begin
               age_in = age_inc;
               // A falling edge of the first pulses takes one bit per line.
               if (shift_now) begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     shift_in[i] = {shift_ff[i][SAMPLE_BITS-2:0], levels[i % LINE_W]};
                  end
               end
               if (status.finish) begin
                  hp_in = '0;
               end else begin
                  hp_in        = hp_new;
                  load_rsp     = 1'b1;
                  rsp_data.sck = hp_new[0];
               end
            end
            OP_EMIT: begin
               load_rsp = 1'b1;
               if (mask_ff != '0) begin
                  rsp_data.sample_valid = 1'b1;
                  rsp_data.channel      = CH_W'(sel_idx);
                  rsp_data.sample_value = shift_ff[sel_idx];
                  rsp_data.last         = !status.more;
                  mask_in               = mask_rest;
               end
            end
            default: begin
               load_rsp = 1'b0;
            end
         endcase
      end
   end

   // Result register: holds a beat until the far side takes it.
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            age_ff[i] <= '0;
         end
         waiting_ff   <= 1'b0;
         elapsed_ff   <= '0;
         hp_ff        <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         age_ff       <= age_in;
         waiting_ff   <= waiting_in;
         elapsed_ff   <= elapsed_in;
         hp_ff        <= hp_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (load_rsp) begin
         rsp_ff <= rsp_data;
      end
   end

`ifndef SYNTHESIS
   // The half-period counter is back at zero whenever the poll step runs.
   a_poll_hp_idle: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_POLL) |-> (hp_ff == '0))
      else $error("half-period counter not cleared during polling");

   // The last flag of an emitted beat matches an emptied sample mask.
   a_emit_last: assert property (@(posedge clock) disable iff (reset)
      (ctl.fire && ctl.op == OP_EMIT) |-> (rsp_data.last == (mask_in == '0)))
      else $error("last flag disagrees with remaining sample mask");

   // Finished samples come only from the emit step.
   a_sample_src: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && rsp_data.sample_valid) |-> (ctl.op == OP_EMIT))
      else $error("sample beat loaded outside the emit step");
`endif

endmodule

[sv/multi_channel_load_cell_reader_top.sv]
// Top level of the multi-channel load cell reader: configuration registers,
// microcode sequencer and datapath. Depends on mclr_pkg, sequencer, datapath.
// Latency: a result beat is valid the cycle after the input beat that makes it.
// Throughput: one input beat per cycle while polling or clocking if not stalled;
// a read's last beat brings one emit step per sampled channel, req_stall high.
// Reset is synchronous and active high: registers take defaults, state clears.
module multi_channel_load_cell_reader_top #(
   parameter int CHANNELS = mclr_pkg::CHANNELS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  mclr_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mclr_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mclr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mclr_pkg::CSR_DATA_W-1:0]      csr_data
);
   import mclr_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   ctl_type    ctl;
   status_type status;

   // Register writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STALE_LIMIT:    cfg_in.stale_limit = csr_data;
            CSR_WAIT_LIMIT:     cfg_in.wait_limit  = csr_data;
            CSR_CHANNEL_ENABLE: cfg_in.enable      = csr_data[LINE_W-1:0];
            default:            cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{stale_limit: STALE_RESET, wait_limit: WAIT_RESET,
                     enable: ENABLE_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Microcode control.
   mclr_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .ctl       (ctl),
      .req_stall (req_stall)
   );

   // Timers, shift registers and result register.
   mclr_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .cfg         (cfg_ff),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
